// ----- hdl/two_level_page_table_manager_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the page table manager
// Shared assertion forms, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_PAGE_TABLE_MANAGER_TOP_ASSERT_SVH
`define TWO_LEVEL_PAGE_TABLE_MANAGER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define TLPTM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tlptm assertion failed");
`define TLPTM_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("tlptm forbidden condition");
`else
`define TLPTM_ASSERT(lbl, clk, rst, prop)
`define TLPTM_NEVER(lbl, clk, rst, cond)
`endif

`endif

// ----- hdl/tlptm_pkg.sv -----
// ----------------------------------------------------------------------------
// Page table manager package
// Request and status codes, fixed field widths and the queued item type.
// ----------------------------------------------------------------------------
package tlptm_pkg;

  localparam int DIR_SIZE = 1024;
  localparam int IDX_W    = 10;
  localparam int OFF_W    = 12;

  localparam logic [1:0] REQ_MAP      = 2'd0;
  localparam logic [1:0] REQ_UNMAP    = 2'd1;
  localparam logic [1:0] REQ_LOOKUP   = 2'd2;
  localparam logic [1:0] REQ_READ_DIR = 2'd3;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_UNALIGNED   = 3'd1;
  localparam logic [2:0] ST_NO_TABLE    = 3'd2;
  localparam logic [2:0] ST_NOT_ENABLED = 3'd3;
  localparam logic [2:0] ST_NOT_MAPPED  = 3'd4;

  localparam logic [OFF_W-1:0] DIR_FLAGS = 12'h003;

  typedef struct packed {
    logic [1:0]       req;
    logic [31:0]      virt;
    logic [19:0]      phys_hi;
    logic [OFF_W-1:0] flags;
    logic [IDX_W-1:0] dsel;
    logic             bad_virt;
    logic             bad_phys;
  } item_t;

endpackage

// ----- hdl/tlptm_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tlptm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/tlptm_front.sv -----
// ----------------------------------------------------------------------------
// Page table manager front end
// Accepts items, flags misaligned addresses and queues them for the back end.
// ----------------------------------------------------------------------------
module tlptm_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 busy,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           req_type,
  input  logic [31:0]          vaddr,
  input  logic [31:0]          phys_addr,
  input  logic [11:0]          entry_flags,
  input  logic [9:0]           dir_index,
  input  logic                 pop,
  output logic                 empty,
  output tlptm_pkg::item_t     head
);

  tlptm_pkg::item_t q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  tlptm_pkg::item_t item;

  assign in_stall = busy || (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign empty    = (count == 2'd0);
  assign head     = q[rd_ptr];

  always_comb begin
    item.req      = req_type;
    item.virt     = vaddr;
    item.phys_hi  = phys_addr[31:12];
    item.flags    = entry_flags;
    item.dsel     = dir_index;
    item.bad_virt = (vaddr[11:0] != 12'd0);
    item.bad_phys = (phys_addr[11:0] != 12'd0);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- hdl/tlptm_back.sv -----
// ----------------------------------------------------------------------------
// Page table manager back end
// Clears the memories after reset, then walks the directory per item and the table as the request needs.
// ----------------------------------------------------------------------------
`include "two_level_page_table_manager_top_assert.svh"

module tlptm_back #(
  parameter int TABLE_COUNT = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             paging_enabled,
  input  logic [19:0]      pool_base,
  input  logic             empty,
  input  tlptm_pkg::item_t head,
  output logic             pop,
  output logic             busy,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       status,
  output logic             mapped,
  output logic [31:0]      phys_frame_addr,
  output logic [31:0]      entry_value,
  output logic             tlb_flush,
  output logic [31:0]      flush_addr
);

  localparam int SLOT_W    = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
  localparam int USED_W    = $clog2(TABLE_COUNT + 1);
  localparam int TAB_DEPTH = TABLE_COUNT * tlptm_pkg::DIR_SIZE;
  localparam int TAB_AW    = $clog2(TAB_DEPTH);
  localparam int DIR_W     = SLOT_W + 32;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_DIR   = 4'b0100,
    S_TBL   = 4'b1000
  } state_t;

  state_t           state;
  tlptm_pkg::item_t cur;
  logic [TAB_AW-1:0] clr_cnt;
  logic [USED_W-1:0] used;

  logic              dir_we;
  logic [9:0]        dir_waddr;
  logic [DIR_W-1:0]  dir_wdata;
  logic [9:0]        dir_raddr;
  logic [DIR_W-1:0]  dir_rdata;
  logic              tab_we;
  logic [TAB_AW-1:0] tab_waddr;
  logic [31:0]       tab_wdata;
  logic [TAB_AW-1:0] tab_raddr;
  logic [31:0]       tab_rdata;

  logic [SLOT_W-1:0] dir_slot;
  logic [SLOT_W-1:0] new_slot;
  logic [31:0]       dir_entry;
  logic              present;
  logic              room;
  logic              clr_dir;
  logic [19:0]       new_frame;
  logic [9:0]        tidx;
  logic              tbl_walk;

  assign dir_slot  = dir_rdata[DIR_W-1:32];
  assign dir_entry = dir_rdata[31:0];
  assign present   = dir_entry[0];
  assign new_slot  = SLOT_W'(used);
  assign room      = (used < USED_W'(TABLE_COUNT));
  assign new_frame = pool_base + 20'(used);
  assign tidx      = cur.virt[21:12];
  assign clr_dir   = ({1'b0, clr_cnt} < (TAB_AW + 1)'(tlptm_pkg::DIR_SIZE));
  assign busy      = (state == S_CLEAR);
  assign pop       = (state == S_IDLE) && !empty && !out_valid;
  assign tbl_walk  = (cur.req == tlptm_pkg::REQ_LOOKUP) && paging_enabled && present;

  always_comb begin
    dir_we    = 1'b0;
    dir_waddr = cur.virt[31:22];
    dir_wdata = {new_slot, new_frame, tlptm_pkg::DIR_FLAGS};
    dir_raddr = (head.req == tlptm_pkg::REQ_READ_DIR) ? head.dsel : head.virt[31:22];
    tab_we    = 1'b0;
    tab_waddr = TAB_AW'({dir_slot, tidx});
    tab_wdata = 32'd0;
    tab_raddr = TAB_AW'({dir_slot, tidx});
    if (state == S_CLEAR) begin
      dir_we    = clr_dir;
      dir_waddr = clr_cnt[9:0];
      dir_wdata = '0;
      tab_we    = 1'b1;
      tab_waddr = clr_cnt;
    end else if (state == S_DIR) begin
      if (cur.req == tlptm_pkg::REQ_MAP && !cur.bad_virt && !cur.bad_phys
          && (present || room)) begin
        tab_we    = 1'b1;
        tab_waddr = TAB_AW'({present ? dir_slot : new_slot, tidx});
        tab_wdata = {cur.phys_hi, cur.flags};
        dir_we    = !present;
      end else if (cur.req == tlptm_pkg::REQ_UNMAP && !cur.bad_virt && present) begin
        tab_we = 1'b1;
      end
    end
  end

  tlptm_ram #(.WIDTH(DIR_W), .DEPTH(tlptm_pkg::DIR_SIZE)) u_dir (
    .clk(clk), .we(dir_we), .waddr(dir_waddr), .wdata(dir_wdata),
    .raddr(dir_raddr), .rdata(dir_rdata)
  );

  tlptm_ram #(.WIDTH(32), .DEPTH(TAB_DEPTH)) u_tab (
    .clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
    .raddr(tab_raddr), .rdata(tab_rdata)
  );

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == TAB_AW'(TAB_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop) begin
            state <= S_DIR;
          end
        end
        S_DIR: begin
          state           <= tbl_walk ? S_TBL : S_IDLE;
          out_valid       <= !tbl_walk;
          status          <= tlptm_pkg::ST_OK;
          mapped          <= 1'b0;
          phys_frame_addr <= 32'd0;
          entry_value     <= 32'd0;
          tlb_flush       <= 1'b0;
          flush_addr      <= 32'd0;
          case (cur.req)
            tlptm_pkg::REQ_MAP: begin
              if (cur.bad_virt || cur.bad_phys) begin
                status <= tlptm_pkg::ST_UNALIGNED;
              end else if (!present && !room) begin
                status <= tlptm_pkg::ST_NO_TABLE;
              end else begin
                if (!present) begin
                  used <= used + 1'b1;
                end
                tlb_flush  <= paging_enabled;
                flush_addr <= paging_enabled ? cur.virt : 32'd0;
              end
            end
            tlptm_pkg::REQ_UNMAP: begin
              if (cur.bad_virt) begin
                status <= tlptm_pkg::ST_UNALIGNED;
              end else if (!present) begin
                status <= tlptm_pkg::ST_NOT_MAPPED;
              end else begin
                tlb_flush  <= paging_enabled;
                flush_addr <= paging_enabled ? cur.virt : 32'd0;
              end
            end
            tlptm_pkg::REQ_LOOKUP: begin
              if (!paging_enabled) begin
                status <= tlptm_pkg::ST_NOT_ENABLED;
              end else if (!present) begin
                status <= cur.bad_virt ? tlptm_pkg::ST_UNALIGNED : tlptm_pkg::ST_NOT_MAPPED;
              end
            end
            default: begin
              if (!paging_enabled) begin
                status <= tlptm_pkg::ST_NOT_ENABLED;
              end else begin
                entry_value <= dir_entry;
              end
            end
          endcase
        end
        S_TBL: begin
          state       <= S_IDLE;
          out_valid   <= 1'b1;
          entry_value <= tab_rdata;
          if (cur.bad_virt) begin
            status <= tlptm_pkg::ST_UNALIGNED;
          end else if (!tab_rdata[0]) begin
            status <= tlptm_pkg::ST_NOT_MAPPED;
          end else begin
            mapped          <= 1'b1;
            phys_frame_addr <= {tab_rdata[31:12], 12'd0};
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TLPTM_NEVER(a_used_bound, clk, rst, used > USED_W'(TABLE_COUNT))
  `TLPTM_ASSERT(a_flush_ok, clk, rst, out_valid && tlb_flush |-> status == tlptm_pkg::ST_OK)
  `TLPTM_ASSERT(a_mapped_ok, clk, rst, out_valid && mapped |-> status == tlptm_pkg::ST_OK)
  `TLPTM_NEVER(a_pop_clear, clk, rst, pop && busy)

endmodule

// ----- hdl/two_level_page_table_manager_top.sv -----
// ----------------------------------------------------------------------------
// Two-level page table manager
// Page directory plus a never-freed pool of page tables; map, unmap, lookup
// and raw directory read, one result item per request item.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all TABLE_COUNT*1024
// table entries (16384 by default), clearing the 1024 directory entries
// alongside the first of them; in_stall stays high meanwhile. Each item
// then passes through the back end as directory read, decision/write and
// output, and a lookup of a present slot adds the dependent table read; the
// registered reads of the directory and table memories set this. A two-item
// queue decouples input acceptance from execution.
module two_level_page_table_manager_top #(
  parameter int TABLE_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [31:0] vaddr,
  input  logic [31:0] phys_addr,
  input  logic [11:0] entry_flags,
  input  logic [9:0]  dir_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic        mapped,
  output logic [31:0] phys_frame_addr,
  output logic [31:0] entry_value,
  output logic        tlb_flush,
  output logic [31:0] flush_addr,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] ADDR_PAGING = 3'd0;
  localparam logic [2:0] ADDR_BASE   = 3'd4;

  logic             paging_enabled;
  logic [19:0]      pool_base;
  logic             busy;
  logic             empty;
  logic             pop;
  tlptm_pkg::item_t head;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      paging_enabled <= 1'b0;
      pool_base      <= 20'd0;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        ADDR_PAGING: paging_enabled <= pwdata[0];
        ADDR_BASE:   pool_base      <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ADDR_PAGING: prdata = {31'd0, paging_enabled};
      ADDR_BASE:   prdata = {12'd0, pool_base};
      default:     prdata = 32'd0;
    endcase
  end

  tlptm_front u_front (
    .clk(clk), .rst(rst), .busy(busy),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .vaddr(vaddr), .phys_addr(phys_addr),
    .entry_flags(entry_flags), .dir_index(dir_index),
    .pop(pop), .empty(empty), .head(head)
  );

  tlptm_back #(.TABLE_COUNT(TABLE_COUNT)) u_back (
    .clk(clk), .rst(rst),
    .paging_enabled(paging_enabled), .pool_base(pool_base),
    .empty(empty), .head(head), .pop(pop), .busy(busy),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .mapped(mapped), .phys_frame_addr(phys_frame_addr),
    .entry_value(entry_value), .tlb_flush(tlb_flush), .flush_addr(flush_addr)
  );

endmodule
